>>> design/swm_pkg.sv
// Shared constants, types and helpers of the sliding window median filter.
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int SAMPLE_W   = 32;
    localparam int AGE_W      = $clog2(WINDOW_MAX);
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int WS_W       = 6;

    localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [AGE_W-1:0]           age_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [WS_W-1:0]            ws_t;

    // Broadcast from the control logic to every cell
    typedef struct packed {
        logic    fire;
        logic    evict;
        age_t    old_age;
        sample_t x;
    } swm_bcast_t;

    // Stored entry handed from a cell to its left neighbor
    typedef struct packed {
        sample_t val;
        age_t    age;
    } swm_entry_t;

    // Entry after eviction, handed from a cell to its right neighbor
    typedef struct packed {
        sample_t val;
        age_t    age;
        logic    le;
        logic    del;
    } swm_link_t;

    // Clamp the programmed window size to 1 .. WINDOW_MAX
    function automatic cnt_t eff_size(input ws_t ws);
        cnt_t k;
        if (ws == '0)
        begin
            k = CNT_W'(1);
        end
        else if (32'(ws) > WINDOW_MAX)
        begin
            k = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            k = CNT_W'(ws);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

>>> design/sliding_window_median_top.sv
// Sliding window median filter: a row of sorting cells plus stream control.
//
// The filter accepts one sample per clock cycle and, once window_size samples
// (clamped to 1 .. 32) have arrived, returns the lower median of the latest
// that many samples. A sample transfer that completes a window updates the cells
// and sets a pending flag; the median is registered onto m_tdata once the
// output register is free. The rate is set by the row of 32 cells: each cell
// compares its entry against the new sample, the oldest entry drops out and
// the row shifts to keep ascending order. The input stalls only while a
// result waits to be read and the output register is still held by
// m_tready low. Writing window_size restarts filling; no clearing pass is
// needed after reset.
`default_nettype none

module sliding_window_median_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Configuration write: window_size
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [5:0]          cfg_data,
    // Input stream, tdata: [31:0] sample
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic signed [31:0]  s_tdata,
    // Output stream, tdata: [31:0] median
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic signed [31:0]       m_tdata
);

    localparam int N = swm_pkg::WINDOW_MAX;

    swm_pkg::ws_t     ws_reg;
    swm_pkg::cnt_t    fill_reg;
    swm_pkg::cnt_t    fill_next;
    logic             pend_reg;
    swm_pkg::idx_t    rank_reg;
    logic             out_valid_reg;
    swm_pkg::sample_t out_data_reg;

    swm_pkg::cnt_t    keff;
    swm_pkg::cnt_t    rcount;
    logic             full;
    logic             in_fire;
    logic             cfg_fire;
    logic             out_load;
    logic             result;
    swm_pkg::cnt_t    rank_full;

    swm_pkg::swm_bcast_t bc;
    swm_pkg::swm_link_t  links [N+1];
    swm_pkg::swm_entry_t entries [N+1];

    // Window bookkeeping
    assign keff      = swm_pkg::eff_size(ws_reg);
    assign full      = (fill_reg == keff);
    assign rcount    = fill_reg - swm_pkg::CNT_W'(full);
    assign fill_next = rcount + swm_pkg::CNT_W'(1);
    assign result    = (fill_next == keff);
    assign rank_full = (keff - swm_pkg::CNT_W'(1)) >> 1;

    // Handshakes
    assign out_load  = !out_valid_reg || m_tready;
    assign s_tready  = !pend_reg || out_load;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign bc.fire    = in_fire;
    assign bc.evict   = full;
    assign bc.old_age = swm_pkg::AGE_W'(keff - swm_pkg::CNT_W'(1));
    assign bc.x       = s_tdata;

    // Ends of the row
    assign links[0].val = '0;
    assign links[0].age = '0;
    assign links[0].le  = 1'b1;
    assign links[0].del = 1'b0;
    assign entries[N]   = '0;

    // Row of sorting cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic valid;
        logic rvalid;

        assign valid  = swm_pkg::CNT_W'(i) < fill_reg;
        assign rvalid = swm_pkg::CNT_W'(i) < rcount;

        swm_cell u_cell (
            .clk       (clk),
            .bc        (bc),
            .valid     (valid),
            .rvalid    (rvalid),
            .left      (links[i]),
            .right     (entries[i+1]),
            .link_out  (links[i+1]),
            .entry_out (entries[i])
        );
    end

    // Window size register and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= swm_pkg::WS_RESET;
            fill_reg <= '0;
        end
        else if (cfg_fire)
        begin
            ws_reg   <= cfg_data;
            fill_reg <= '0;
        end
        else if (in_fire)
        begin
            fill_reg <= fill_next;
        end
    end

    // Track a result whose median is still to be read from the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            pend_reg <= result;
        end
        else if (out_load)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rank_reg <= rank_full[swm_pkg::IDX_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && pend_reg)
        begin
            out_data_reg <= entries[{1'b0, rank_reg}].val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> design/swm_cell.sv
// One cell of the sorted window row: holds one entry and its age.
`default_nettype none

module swm_cell (
    input  wire logic               clk,
    input  wire swm_pkg::swm_bcast_t bc,
    input  wire logic               valid,
    input  wire logic               rvalid,
    input  wire swm_pkg::swm_link_t  left,
    input  wire swm_pkg::swm_entry_t right,
    output swm_pkg::swm_link_t       link_out,
    output swm_pkg::swm_entry_t      entry_out
);

    swm_pkg::sample_t val_reg;
    swm_pkg::sample_t val_next;
    swm_pkg::age_t    age_reg;
    swm_pkg::age_t    age_next;

    logic             own_del;
    logic             del;
    swm_pkg::sample_t r_val;
    swm_pkg::age_t    r_age;
    logic             r_le;

    // Mark the oldest entry for eviction
    assign own_del = bc.evict && valid && (age_reg == bc.old_age);
    assign del     = left.del || own_del;

    // Close the gap left by the evicted entry
    assign r_val = del ? right.val : val_reg;
    assign r_age = del ? right.age : age_reg;
    assign r_le  = rvalid && (r_val <= bc.x);

    // Hold, take the new sample, or take the left neighbor's entry
    always_comb
    begin
        if (r_le)
        begin
            val_next = r_val;
            age_next = r_age + swm_pkg::AGE_W'(1);
        end
        else if (left.le)
        begin
            val_next = bc.x;
            age_next = '0;
        end
        else
        begin
            val_next = left.val;
            age_next = left.age + swm_pkg::AGE_W'(1);
        end
    end

    // Update the entry on an input transfer
    always_ff @(posedge clk)
    begin
        if (bc.fire)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign link_out.val  = r_val;
    assign link_out.age  = r_age;
    assign link_out.le   = r_le;
    assign link_out.del  = del;
    assign entry_out.val = val_reg;
    assign entry_out.age = age_reg;

endmodule

`default_nettype wire

>>> design/swm_checker.sv
// Port-level checks of the median filter and their binding to the top level.
`default_nettype none

module swm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic signed [31:0] m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Stall the input only behind a blocked result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    // Raise a result only after a sample transfer
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching sample transfer");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/tb_sliding_window_median_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the sliding window median filter top level.
module tb_sliding_window_median_top;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 55;
    localparam int NUM_PHASES   = 9;

    localparam swm_pkg::sample_t SAMPLE_MIN = swm_pkg::sample_t'(32'h8000_0000);
    localparam swm_pkg::sample_t SAMPLE_MAX = swm_pkg::sample_t'(32'h7fff_ffff);

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    swm_pkg::ws_t     cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    swm_pkg::sample_t s_tdata   = '0;      // [31:0] sample
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    swm_pkg::sample_t m_tdata;             // [31:0] median

    // Predictor state: programmed window and the samples seen since the last write
    swm_pkg::ws_t     window_setting = swm_pkg::WS_RESET;
    swm_pkg::sample_t window_history[$];
    swm_pkg::sample_t expected_medians[$];

    int mismatches      = 0;
    int samples_sent    = 0;
    int medians_checked = 0;
    int window_writes   = 0;
    int src_idle_pct    = 0;
    int sink_idle_pct   = 0;

    logic hold_start = 1'b0;
    int   hold_left  = 0;

    swm_pkg::ws_t phase_windows [NUM_PHASES] = '{6'd32, 6'd63, 6'd5, 6'd33, 6'd2, 6'd17,
                                                 6'd0, 6'd11, 6'd1};

    sliding_window_median_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Free-running clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Clamp the programmed window size to the range the filter supports
    function automatic int effective_window(input swm_pkg::ws_t ws);
        if (ws == '0)
        begin
            return 1;
        end
        if (int'(ws) > swm_pkg::WINDOW_MAX)
        begin
            return swm_pkg::WINDOW_MAX;
        end
        return int'(ws);
    endfunction

    // Draw a sample: full range, a narrow band full of repeats, or an extreme
    function automatic swm_pkg::sample_t random_sample();
        case ($urandom_range(3))
            0: return swm_pkg::sample_t'($urandom);
            1: return swm_pkg::sample_t'(int'($urandom_range(16)) - 8);
            2: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            default: return swm_pkg::sample_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Slide the window by one sample and queue the lower median once it is full
    task automatic predict_median(input swm_pkg::sample_t x);
        int               k;
        int               n;
        int               j;
        swm_pkg::sample_t ordered [swm_pkg::WINDOW_MAX];
        k = effective_window(window_setting);
        window_history = {window_history, x};
        while (window_history.size() > k)
        begin
            void'(window_history.pop_front());
        end
        if (window_history.size() == k)
        begin
            n = 0;
            for (int i = 0; i < k; i++)
            begin
                j = n;
                while (j > 0 && ordered[j-1] > window_history[i])
                begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = window_history[i];
                n++;
            end
            expected_medians = {expected_medians, ordered[(k - 1) / 2]};
        end
    endtask

    task automatic check_median(input swm_pkg::sample_t got);
        swm_pkg::sample_t want;
        if (expected_medians.size() == 0)
        begin
            report_mismatch($sformatf("median %0d arrived with none expected", got));
        end
        else
        begin
            want = expected_medians.pop_front();
            medians_checked++;
            if (got !== want)
            begin
                report_mismatch($sformatf("median %0d, expected %0d", got, want));
            end
        end
    endtask

    // Offer one sample after a random gap and hold it until the transfer
    task automatic send_sample(input swm_pkg::sample_t x);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge clk); while (!s_tready);
        predict_median(x);
        samples_sent++;
    endtask

    // Stop offering, wait for every queued median, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_medians.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Program window_size while the filter is idle; filling restarts
    task automatic write_window(input swm_pkg::ws_t value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_setting = value;
        window_history.delete();
        window_writes++;
    endtask

    // Receiver: check each transfer, stall at random or during a long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_median(m_tdata);
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Count down the long receiver hold
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Reset window of three: extremes, sign boundary and repeated values
    task automatic test_reset_window();
        src_idle_pct  = 32;
        sink_idle_pct = 50;
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(swm_pkg::sample_t'(0));
        send_sample(swm_pkg::sample_t'(-1));
        send_sample(swm_pkg::sample_t'(1));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(swm_pkg::sample_t'(0));
    endtask

    // Zero acts as one, a window of one passes samples, two gives the minimum
    task automatic test_clamped_windows();
        write_window(6'd0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(swm_pkg::sample_t'(32'h5555_5555));
        write_window(6'd1);
        send_sample(swm_pkg::sample_t'(32'haaaa_aaaa));
        send_sample(swm_pkg::sample_t'(-1));
        write_window(6'd2);
        send_sample(swm_pkg::sample_t'(5));
        send_sample(swm_pkg::sample_t'(5));
        send_sample(swm_pkg::sample_t'(-5));
        send_sample(swm_pkg::sample_t'(-5));
    endtask

    // Hold the receiver off while samples keep coming so the input stalls
    task automatic test_backpressure();
        write_window(6'd4);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 40; i++)
        begin
            send_sample(random_sample());
        end
    endtask

    // Random samples over several window settings and idle patterns
    task automatic test_random_stream();
        swm_pkg::ws_t ws;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            ws = (p == 5) ? swm_pkg::ws_t'($urandom_range(63)) : phase_windows[p];
            write_window(ws);
            if (p < 3)
            begin
                src_idle_pct  = 32;
                sink_idle_pct = 50;
            end
            else if (p < 6)
            begin
                src_idle_pct  = 50;
                sink_idle_pct = 32;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_sample(random_sample());
            end
        end
    endtask

    // Test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_clamped_windows();
        test_backpressure();
        test_random_stream();
        settle();
        $display("Sent %0d samples over %0d window writes, checked %0d medians.",
                 samples_sent, window_writes, medians_checked);
        $display("Windows covered: reset value, 0, 1, 2, 32, above 32, and a long output hold.");
        if (mismatches == 0)
        begin
            $display("tb_sliding_window_median_top passed");
        end
        else
        begin
            $display("tb_sliding_window_median_top failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timeout with %0d medians outstanding", expected_medians.size());
        $display("tb_sliding_window_median_top failed");
        $finish;
    end

endmodule

>>> sim.f
design/swm_pkg.sv
design/swm_cell.sv
design/sliding_window_median_top.sv
design/swm_checker.sv
bench/tb_sliding_window_median_top.sv
